FILE: rtl/rsl_pkg.sv
// ----------------------------------------------------------------------------
// rsl_pkg
// Shared constants, register codes and the square root cell payload for the
// radial spotlight luminance core.
// ----------------------------------------------------------------------------
package rsl_pkg;

	localparam int COORD_BITS    = 12;
	localparam int CFG_BITS      = 14;
	localparam int CFG_IDX_BITS  = 1;
	localparam int LUMA_BITS     = 16;
	localparam int DIFF_BITS     = 15;
	localparam int SQ_BITS       = 28;
	localparam int D2_BITS       = SQ_BITS + 1;
	localparam int NEAR_BITS     = 15;
	localparam int FRAC_BITS     = 16;
	localparam int RAD_BITS      = 32;
	localparam int ROOT_BITS     = 16;
	localparam int ROOT_IDX_BITS = 4;
	localparam int TRIAL_BITS    = RAD_BITS + 1;
	localparam int ATTEN_MUL_BITS = 11;
	localparam int ATTEN_BITS    = 17;
	localparam int FACTOR_BITS   = 17;
	localparam int PROD_BITS     = LUMA_BITS + FACTOR_BITS;
	localparam int FIFO_DEPTH    = 32;
	localparam int FIFO_AW       = 5;
	localparam int FIFO_CW       = FIFO_AW + 1;

	localparam logic [D2_BITS-1:0]        FAR_D2      = D2_BITS'(25600);
	localparam logic [FACTOR_BITS-1:0]    FAR_SCALE   = FACTOR_BITS'(13107);
	localparam logic [FACTOR_BITS-1:0]    UNITY       = FACTOR_BITS'(65536);
	localparam logic [ATTEN_MUL_BITS-1:0] ATTEN_MUL   = ATTEN_MUL_BITS'(1311);
	localparam int                        ATTEN_SHIFT = 10;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CENTER_COL = 1'b0,
		REG_CENTER_ROW = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic                 far;
		logic [LUMA_BITS-1:0] luma;
		logic [RAD_BITS-1:0]  rem;
		logic [ROOT_BITS-1:0] root;
	} rsl_cell_t;

endpackage

FILE: rtl/rsl_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rsl_sqrt_cell
// One cell of the square root chain: decides one root bit by trial
// subtraction and hands the remainder, partial root and pixel on.
// ----------------------------------------------------------------------------
module rsl_sqrt_cell (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [rsl_pkg::ROOT_IDX_BITS-1:0]  bit_idx,
	input  logic                               vld_in,
	input  rsl_pkg::rsl_cell_t                 cell_in,
	output logic                               vld_s1,
	output rsl_pkg::rsl_cell_t                 cell_s1
);
	import rsl_pkg::*;

	logic [TRIAL_BITS-1:0] trial;
	logic                  fit;
	rsl_cell_t             cell_nxt;

	always_comb begin
		trial = ({(TRIAL_BITS-ROOT_BITS)'(0), cell_in.root} << ({1'b0, bit_idx} + 5'd1))
			+ (TRIAL_BITS'(1) << {bit_idx, 1'b0});
		fit = {1'b0, cell_in.rem} >= trial;
		cell_nxt = cell_in;
		if (fit) begin
			cell_nxt.rem  = cell_in.rem - trial[RAD_BITS-1:0];
			cell_nxt.root = cell_in.root | (ROOT_BITS'(1) << bit_idx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		cell_s1 <= cell_nxt;
	end

endmodule

FILE: rtl/rsl_fifo.sv
// ----------------------------------------------------------------------------
// rsl_fifo
// Result buffer behind the pipeline; holds finished results while the
// receiver stalls.
// ----------------------------------------------------------------------------
module rsl_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [rsl_pkg::LUMA_BITS-1:0]   wr_data,
	input  logic                            rd_en,
	output logic                            rd_valid,
	output logic [rsl_pkg::LUMA_BITS-1:0]   rd_data
);
	import rsl_pkg::*;

	logic [LUMA_BITS-1:0] mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   count_q;
	logic                 head_vld_q;
	logic [LUMA_BITS-1:0] head_q;
	logic                 pop;
	logic                 load;
	logic                 mem_rd;
	logic                 mem_wr;

	// head register in front of the array, filled from the array or straight
	// from the write side when the array is empty
	assign rd_valid = head_vld_q;
	assign rd_data  = head_q;
	assign pop      = rd_en && head_vld_q;
	assign load     = !head_vld_q || pop;
	assign mem_rd   = load && (count_q != '0);
	assign mem_wr   = wr_en && !(load && (count_q == '0));

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
		if (mem_rd) begin
			head_q <= mem_q[rd_ptr_q];
		end else if (load && wr_en) begin
			head_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			count_q    <= '0;
			head_vld_q <= 1'b0;
		end else begin
			if (mem_wr) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (mem_rd) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (load) begin
				head_vld_q <= mem_rd || wr_en;
			end
			case ({mem_wr, mem_rd})
				2'b10:   count_q <= count_q + FIFO_CW'(1);
				2'b01:   count_q <= count_q - FIFO_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/radial_spotlight_luma_core.sv
// ----------------------------------------------------------------------------
// radial_spotlight_luma_core
// Radial spotlight on pixel luminance: each pixel is dimmed by its distance
// from a configurable centre.
// ----------------------------------------------------------------------------
// usage
//   config: write center_col (index 0) or center_row (index 1) with cfg_wr_en,
//   low 14 bits of cfg_data taken as signed; write only while no pixel is
//   in flight
//   input: one pixel per transfer on in_valid / in_ready (pix_col, pix_row,
//   luma_in); output: one luma_out per pixel on out_valid / out_ready, in order
//   pipeline: the dx/dy, square and sum stages, the 16-cell square root chain
//   and two multiply stages
//   throughput: one pixel per cycle while out_ready is high
//   stall: the pipeline never stops; results collect in a 32-entry buffer and
//   in_ready drops once 32 pixels are accepted but not yet transferred out
//   reset: centre returns to (0, 0), pipeline and buffer empty
// ----------------------------------------------------------------------------
module radial_spotlight_luma_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [rsl_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  logic [rsl_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [rsl_pkg::COORD_BITS-1:0]     pix_col,
	input  logic [rsl_pkg::COORD_BITS-1:0]     pix_row,
	input  logic [rsl_pkg::LUMA_BITS-1:0]      luma_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [rsl_pkg::LUMA_BITS-1:0]      luma_out
);
	import rsl_pkg::*;

	logic [CFG_BITS-1:0]  center_col_q;
	logic [CFG_BITS-1:0]  center_row_q;
	logic [FIFO_CW-1:0]   credit_q;
	logic                 in_xfer;
	logic                 out_xfer;

	// stage 1: offsets
	logic                        vld_s1;
	logic signed [DIFF_BITS-1:0] dx_s1;
	logic signed [DIFF_BITS-1:0] dy_s1;
	logic [LUMA_BITS-1:0]        luma_s1;
	// stage 2: squares
	logic                          vld_s2;
	logic signed [2*DIFF_BITS-1:0] dx_sq;
	logic signed [2*DIFF_BITS-1:0] dy_sq;
	logic [SQ_BITS-1:0]            sqx_s2;
	logic [SQ_BITS-1:0]            sqy_s2;
	logic [LUMA_BITS-1:0]          luma_s2;
	// stage 3: distance and range check
	logic [D2_BITS-1:0] d2;
	rsl_cell_t          cell_nxt;
	logic               vld_s3;
	rsl_cell_t          cell_s3;
	// square root chain
	logic      vld_c  [ROOT_BITS+1];
	rsl_cell_t cell_c [ROOT_BITS+1];
	// stage 4: attenuation
	logic [ROOT_BITS+ATTEN_MUL_BITS-1:0] atten_p;
	logic                                vld_s4;
	logic                                far_s4;
	logic [LUMA_BITS-1:0]                luma_s4;
	logic [ATTEN_BITS-1:0]               atten_s4;
	// final scale
	logic [FACTOR_BITS-1:0] factor;
	logic [PROD_BITS-1:0]   prod;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	assign in_ready = credit_q != FIFO_CW'(FIFO_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_col_q <= '0;
			center_row_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_CENTER_COL: center_col_q <= cfg_data;
				REG_CENTER_ROW: center_row_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({in_xfer, out_xfer})
				2'b10:   credit_q <= credit_q + FIFO_CW'(1);
				2'b01:   credit_q <= credit_q - FIFO_CW'(1);
				default: credit_q <= credit_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_xfer;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_c[ROOT_BITS];
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= $signed({(DIFF_BITS-COORD_BITS)'(0), pix_col})
			- $signed({{(DIFF_BITS-CFG_BITS){center_col_q[CFG_BITS-1]}}, center_col_q});
		dy_s1 <= $signed({(DIFF_BITS-COORD_BITS)'(0), pix_row})
			- $signed({{(DIFF_BITS-CFG_BITS){center_row_q[CFG_BITS-1]}}, center_row_q});
		luma_s1 <= luma_in;
	end

	assign dx_sq = dx_s1 * dx_s1;
	assign dy_sq = dy_s1 * dy_s1;

	always_ff @(posedge clk) begin
		sqx_s2  <= dx_sq[SQ_BITS-1:0];
		sqy_s2  <= dy_sq[SQ_BITS-1:0];
		luma_s2 <= luma_s1;
	end

	always_comb begin
		d2            = {1'b0, sqx_s2} + {1'b0, sqy_s2};
		cell_nxt.far  = d2 > FAR_D2;
		cell_nxt.luma = luma_s2;
		cell_nxt.root = '0;
		cell_nxt.rem  = cell_nxt.far ? '0
			: {(RAD_BITS-NEAR_BITS-FRAC_BITS)'(0), d2[NEAR_BITS-1:0], FRAC_BITS'(0)};
	end

	always_ff @(posedge clk) begin
		cell_s3 <= cell_nxt;
	end

	assign vld_c[0]  = vld_s3;
	assign cell_c[0] = cell_s3;

	for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
		rsl_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.bit_idx (ROOT_IDX_BITS'(ROOT_BITS - 1 - i)),
			.vld_in  (vld_c[i]),
			.cell_in (cell_c[i]),
			.vld_s1  (vld_c[i+1]),
			.cell_s1 (cell_c[i+1])
		);
	end

	assign atten_p = cell_c[ROOT_BITS].root * ATTEN_MUL;

	always_ff @(posedge clk) begin
		far_s4   <= cell_c[ROOT_BITS].far;
		luma_s4  <= cell_c[ROOT_BITS].luma;
		atten_s4 <= atten_p[ATTEN_SHIFT +: ATTEN_BITS];
	end

	assign factor = far_s4 ? FAR_SCALE : UNITY - atten_s4;
	assign prod   = {(PROD_BITS-LUMA_BITS)'(0), luma_s4}
		* {(PROD_BITS-FACTOR_BITS)'(0), factor};

	rsl_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (vld_s4),
		.wr_data  (prod[FRAC_BITS +: LUMA_BITS]),
		.rd_en    (out_ready),
		.rd_valid (out_valid),
		.rd_data  (luma_out)
	);

endmodule

FILE: rtl/rsl_checker.sv
// ----------------------------------------------------------------------------
// rsl_checker
// Port-level checks on the radial spotlight luminance core, bound to the
// top level.
// ----------------------------------------------------------------------------
module rsl_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [rsl_pkg::LUMA_BITS-1:0]      luma_out
);

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transfer");

	// a stalled result keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(luma_out))
		else $error("result changed while stalled");

	// refusing input only while finished results wait
	a_full_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input refused with no result waiting");

	// an output transfer always frees a slot
	a_room_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready)
		else $error("no room after output transfer");

endmodule

bind radial_spotlight_luma_core rsl_checker u_rsl_checker (.*);

FILE: tb/radial_spotlight_luma_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_spotlight_luma_core_tb
// Self-checking bench for the radial spotlight core. Pixels go in through the
// input handshake and a bit-exact model of the distance attenuation predicts
// each luma_out. Results are checked in order against that prediction.
// Directed pixels hit the threshold, the far and near cases and the centre
// extremes. Random phases then vary the centre, the source gaps and the
// sink stalls.
// ----------------------------------------------------------------------------
module radial_spotlight_luma_core_tb;
	import rsl_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int DRAIN_PAD  = 30;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_wr_en;
	cfg_reg_t                cfg_idx;
	logic [CFG_BITS-1:0]     cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [COORD_BITS-1:0]   pix_col;
	logic [COORD_BITS-1:0]   pix_row;
	logic [LUMA_BITS-1:0]    luma_in;
	logic                    out_valid;
	logic                    out_ready;
	logic [LUMA_BITS-1:0]    luma_out;

	logic signed [CFG_BITS-1:0] centre_col;
	logic signed [CFG_BITS-1:0] centre_row;
	logic [LUMA_BITS-1:0]       expected_luma[$];

	int  fail_count;
	int  sent_count;
	int  checked_count;
	int  centre_count;
	int  pause_count;
	int  idle_cycles;
	int  stall_left;
	bit  src_steady;
	bit  sink_steady;
	bit  sink_long;

	radial_spotlight_luma_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pix_col   (pix_col),
		.pix_row   (pix_row),
		.luma_in   (luma_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.luma_out  (luma_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic longint floor_sqrt(input longint v);
		longint root;
		longint trial;
		root = 0;
		for (int i = 15; i >= 0; i--) begin
			trial = root | (longint'(1) << i);
			if (trial * trial <= v)
				root = trial;
		end
		return root;
	endfunction

	function automatic logic [LUMA_BITS-1:0] spotlight_luma(
		input logic [COORD_BITS-1:0] col,
		input logic [COORD_BITS-1:0] row,
		input logic [LUMA_BITS-1:0]  lum
	);
		longint dx;
		longint dy;
		longint d2;
		longint atten;
		longint scaled;
		dx = longint'(int'(col)) - longint'(int'(centre_col));
		dy = longint'(int'(row)) - longint'(int'(centre_row));
		d2 = dx * dx + dy * dy;
		if (d2 > 25600) begin
			scaled = (longint'(lum) * 13107) >>> 16;
		end else begin
			atten  = (floor_sqrt(d2 << 16) * 1311) >>> ATTEN_SHIFT;
			scaled = (longint'(lum) * (65536 - atten)) >>> 16;
		end
		return scaled[LUMA_BITS-1:0];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic int stall_len();
		if (sink_long && $urandom_range(0, 9) == 0)
			return $urandom_range(30, 60);
		return pick_gap();
	endfunction

	function automatic logic [LUMA_BITS-1:0] rand_luma();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		else if (r == 1)
			return '1;
		return LUMA_BITS'($urandom_range(0, 65535));
	endfunction

	// coordinate within 200 pixels of the centre, or anywhere in 0..4095 when that falls off the grid
	function automatic logic [COORD_BITS-1:0] near_coord(input int centre);
		int v;
		v = centre + int'($urandom_range(0, 400)) - 200;
		if (v < 0 || v > 4095)
			v = $urandom_range(0, 4095);
		return COORD_BITS'(v);
	endfunction

	// sink side: random stalls on out_ready
	initial begin
		out_ready  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ready = 1'b0;
				stall_left--;
			end else begin
				out_ready = 1'b1;
				if (!sink_steady)
					stall_left = stall_len();
			end
		end
	end

	// prediction on input transfer, in-order check on output transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_luma.size() == 0) begin
					$error("luma_out transfer with nothing expected, actual %0d", luma_out);
					fail_count++;
				end else begin
					if (luma_out !== expected_luma[0]) begin
						$error("luma_out mismatch: expected %0d, actual %0d",
							expected_luma[0], luma_out);
						fail_count++;
					end
					void'(expected_luma.pop_front());
					checked_count++;
				end
			end
			if (in_valid && in_ready)
				expected_luma.push_back(spotlight_luma(pix_col, pix_row, luma_in));
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
				$display("radial_spotlight_luma_core verification failed");
				$finish;
			end
		end
	end

	task automatic send_pixel(
		input logic [COORD_BITS-1:0] col,
		input logic [COORD_BITS-1:0] row,
		input logic [LUMA_BITS-1:0]  lum
	);
		int gap;
		gap = src_steady ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_col  = col;
		pix_row  = row;
		luma_in  = lum;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_count++;
	endtask

	// source holds off until every expected result has been transferred
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_luma.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_BITS-1:0] value);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_idx   = idx;
		cfg_data  = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		if (idx == REG_CENTER_COL)
			centre_col = value;
		else
			centre_row = value;
	endtask

	task automatic set_centre(input int col, input int row);
		drain();
		write_reg(REG_CENTER_COL, CFG_BITS'(col));
		write_reg(REG_CENTER_ROW, CFG_BITS'(row));
		centre_count++;
	endtask

	task automatic test_reset_centre();
		send_pixel(0, 0, 16'hffff);
		send_pixel(0, 0, 16'h0000);
		send_pixel(160, 0, 16'hffff);
		send_pixel(0, 160, 16'd40000);
		send_pixel(96, 128, 16'hffff);
		send_pixel(161, 0, 16'hffff);
		send_pixel(160, 1, 16'hffff);
		send_pixel(113, 113, 16'hffff);
		send_pixel(4095, 4095, 16'hffff);
		send_pixel(4095, 0, 16'h0001);
		send_pixel(1, 1, 16'hffff);
	endtask

	task automatic test_centre_extremes();
		set_centre(-8192, -8192);
		send_pixel(0, 0, 16'hffff);
		send_pixel(4095, 4095, 16'd12345);
		set_centre(8191, 8191);
		send_pixel(4095, 4095, 16'hffff);
		send_pixel(0, 0, 16'hffff);
		set_centre(4095, 4095);
		send_pixel(4095, 4095, 16'hffff);
		send_pixel(3935, 4095, 16'hffff);
		set_centre(-160, 0);
		send_pixel(0, 0, 16'hffff);
		send_pixel(0, 1, 16'hffff);
		set_centre(-1, -1);
		send_pixel(0, 0, 16'hffff);
	endtask

	// mostly pixels inside or around the spotlight, with one hold-off midway
	task automatic test_near_pixels(input int settings, input int per_setting);
		int cc;
		int cr;
		for (int s = 0; s < settings; s++) begin
			cc = $urandom_range(0, 4095);
			cr = $urandom_range(0, 4095);
			set_centre(cc, cr);
			for (int i = 0; i < per_setting; i++) begin
				if (i == per_setting / 2) begin
					drain();
					pause_count++;
				end
				if ($urandom_range(0, 9) < 8)
					send_pixel(near_coord(cc), near_coord(cr), rand_luma());
				else
					send_pixel(COORD_BITS'($urandom_range(0, 4095)),
						COORD_BITS'($urandom_range(0, 4095)), rand_luma());
			end
		end
	endtask

	task automatic test_wide_centres(input int settings, input int per_setting);
		for (int s = 0; s < settings; s++) begin
			set_centre($urandom_range(0, 16383), $urandom_range(0, 16383));
			for (int i = 0; i < per_setting; i++)
				send_pixel(COORD_BITS'($urandom_range(0, 4095)),
					COORD_BITS'($urandom_range(0, 4095)),
					LUMA_BITS'($urandom_range(0, 65535)));
		end
	endtask

	task automatic test_full_rate(input int items);
		int cc;
		int cr;
		cc = $urandom_range(0, 4095);
		cr = $urandom_range(0, 4095);
		set_centre(cc, cr);
		src_steady  = 1'b1;
		sink_steady = 1'b1;
		for (int i = 0; i < items; i++)
			send_pixel(near_coord(cc), near_coord(cr), rand_luma());
		src_steady  = 1'b0;
		sink_steady = 1'b0;
	endtask

	task automatic test_backpressure(input int items);
		int cc;
		int cr;
		cc = $urandom_range(0, 4095);
		cr = $urandom_range(0, 4095);
		set_centre(cc, cr);
		src_steady = 1'b1;
		sink_long  = 1'b1;
		for (int i = 0; i < items; i++)
			send_pixel(near_coord(cc), near_coord(cr), rand_luma());
		src_steady = 1'b0;
		sink_long  = 1'b0;
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_idx       = REG_CENTER_COL;
		cfg_data      = '0;
		in_valid      = 1'b0;
		pix_col       = '0;
		pix_row       = '0;
		luma_in       = '0;
		centre_col    = '0;
		centre_row    = '0;
		fail_count    = 0;
		sent_count    = 0;
		checked_count = 0;
		centre_count  = 1;
		pause_count   = 0;
		idle_cycles   = 0;
		src_steady    = 1'b0;
		sink_steady   = 1'b0;
		sink_long     = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_reset_centre();
		test_centre_extremes();
		test_near_pixels(4, 150);
		test_wide_centres(5, 100);
		test_full_rate(250);
		test_backpressure(200);
		drain();

		$display("%0d pixels sent, %0d results checked, %0d centre settings, %0d hold-offs",
			sent_count, checked_count, centre_count, pause_count);
		$display("covered threshold, near and far pixels, centre extremes, stalls and full rate");
		if (fail_count == 0)
			$display("radial_spotlight_luma_core verification clean");
		else
			$display("radial_spotlight_luma_core verification failed");
		$finish;
	end

endmodule
